// ===== rtl/qrad_pkg.sv =====
// ----------------------------------------------------------------------------
// qrad_pkg: shared types and constants of the alphanumeric data encoder
// Field widths, request codes, stream constants and the symbol table.
// ----------------------------------------------------------------------------
package qrad_pkg;

  localparam int MSG_LEN_W = 9;
  localparam int CHAR_W    = 8;
  localparam int SYM_W     = 6;
  localparam int CW_W      = 8;
  localparam int IDX_W     = 6;
  localparam int DC_W      = 7;
  localparam int NEED_W    = 13;

  localparam logic       MODE_BEGIN = 1'b0;
  localparam logic       MODE_CHAR  = 1'b1;

  localparam logic [3:0]    MODE_IND      = 4'b0010;
  localparam int            MODE_IND_BITS = 4;
  localparam int            PAIR_BITS     = 11;
  localparam int            ODD_BITS      = 6;
  localparam int            TERM_BITS     = 4;
  localparam int            NUM_SYMBOLS   = 45;
  localparam logic [CW_W-1:0] PAD_A       = 8'd236;
  localparam logic [CW_W-1:0] PAD_B       = 8'd17;
  localparam logic [DC_W-1:0] DC_RESET    = 7'd13;

  // Bit 6 set marks a character outside the table.
  localparam logic [SYM_W:0] SYM_INVALID = 7'd64;

  typedef struct packed {
    logic clear;
    logic bad_char;
    logic overflow;
  } pk_ctrl_t;

  typedef struct packed {
    logic [2:0]      fill;
    logic [DC_W-1:0] sent;
    logic            close;
  } pk_stat_t;

  function automatic logic [SYM_W:0] symbol_of(input logic [CHAR_W-1:0] ch);
    logic [SYM_W:0] s;
    s = SYM_INVALID;
    if (ch >= 8'd48 && ch <= 8'd57) begin
      s = 7'(ch - 8'd48);
    end else if (ch >= 8'd65 && ch <= 8'd90) begin
      s = 7'(ch - 8'd55);
    end else begin
      case (ch)
        8'd32:   s = 7'd36;
        8'd36:   s = 7'd37;
        8'd37:   s = 7'd38;
        8'd42:   s = 7'd39;
        8'd43:   s = 7'd40;
        8'd45:   s = 7'd41;
        8'd46:   s = 7'd42;
        8'd47:   s = 7'd43;
        8'd58:   s = 7'd44;
        default: s = SYM_INVALID;
      endcase
    end
    return s;
  endfunction

endpackage

// ===== rtl/qrad_if.sv =====
// ----------------------------------------------------------------------------
// qrad_if: request and codeword channels of the alphanumeric data encoder
// Valid/ready channels carrying the request and codeword payloads.
// ----------------------------------------------------------------------------
interface qrad_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [qrad_pkg::MSG_LEN_W-1:0] message_length;
  logic [qrad_pkg::CHAR_W-1:0]    char_code;

  modport source(output valid, mode, message_length, char_code, input ready);
  modport sink(input valid, mode, message_length, char_code, output ready);
endinterface

interface qrad_out_if;
  logic                       valid;
  logic                       ready;
  logic [qrad_pkg::CW_W-1:0]  codeword;
  logic [qrad_pkg::IDX_W-1:0] codeword_index;
  logic                       last;
  logic                       bad_char;
  logic                       overflow;

  modport source(output valid, codeword, codeword_index, last, bad_char, overflow,
                 input ready);
  modport sink(input valid, codeword, codeword_index, last, bad_char, overflow,
               output ready);
endinterface

// ===== rtl/qr_alphanumeric_data_encoder_top.sv =====
// ----------------------------------------------------------------------------
// qr_alphanumeric_data_encoder_top: QR alphanumeric mode data codeword builder
// Packs mode indicator, character count, character pairs, terminator, zero
// fill and pad bytes into data codewords, one bit per cycle when not stalled.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  req_i     in   valid/ready          mode, message_length, char_code
//  cw_o      out  valid/ready          codeword, codeword_index, last,
//                                      bad_char, overflow
//  cfg       in   data_codewords_we_i  data_codewords_i (capacity, reset 13)
//
// Every stream bit passes through the bit shifter: a begin request sends
// 4+COUNT_BITS bits, a character 0, 6 or 11 bits, and each pad codeword 8,
// with sequencing states between steps.
// Reset clears the sequencer, flags and capacity register to their idle values.
// A request is taken only while the sequencer idles; a stalled codeword output
// holds the shifter once the next byte is complete.
// ----------------------------------------------------------------------------
module qr_alphanumeric_data_encoder_top #(
  parameter int COUNT_BITS    = 9,
  parameter int MAX_CODEWORDS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      data_codewords_we_i,
  input  logic [qrad_pkg::DC_W-1:0] data_codewords_i,
  qrad_in_if.sink                   req_i,
  qrad_out_if.source                cw_o
);
  import qrad_pkg::*;

  localparam int SH_W  = MODE_IND_BITS + COUNT_BITS;
  localparam int LEN_W = $clog2(SH_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BODY,
    S_TERM,
    S_FILL,
    S_PAD
  } state_e;

  state_e               state_q, state_d;
  logic                 active_q, active_d;
  logic [MSG_LEN_W-1:0] chars_left_q, chars_left_d;
  logic [SYM_W-1:0]     held_q, held_d;
  logic                 held_v_q, held_v_d;
  logic                 bad_q, bad_d;
  logic                 ovf_q, ovf_d;
  logic                 pad_sel_q, pad_sel_d;
  logic [DC_W-1:0]      dc_q;

  logic [DC_W-1:0]      cap;
  logic [NEED_W-1:0]    need;
  logic [NEED_W-1:0]    room_bits;
  logic [SYM_W:0]       sym_raw;
  logic [SYM_W-1:0]     sym;
  logic [PAIR_BITS-1:0] pair_val;

  logic                 sh_load, sh_busy, sh_bit_valid, sh_bit, pk_bit_ready;
  logic [SH_W-1:0]      sh_value;
  logic [LEN_W-1:0]     sh_len;
  pk_ctrl_t             pk_ctrl;
  pk_stat_t             pk_stat;

  // Saturate the capacity register to 1..MAX_CODEWORDS.
  always_comb begin
    cap = dc_q;
    if (dc_q == '0) begin
      cap = DC_W'(1);
    end else if (int'(dc_q) > MAX_CODEWORDS) begin
      cap = DC_W'(MAX_CODEWORDS);
    end
  end

  // Message bits needed, decided once at the begin request.
  assign need = NEED_W'(MODE_IND_BITS + COUNT_BITS)
              + NEED_W'(req_i.message_length[MSG_LEN_W-1:1]) * NEED_W'(PAIR_BITS)
              + (req_i.message_length[0] ? NEED_W'(ODD_BITS) : NEED_W'(0));
  assign room_bits = NEED_W'({cap, 3'b000});

  assign sym_raw  = symbol_of(req_i.char_code);
  assign sym      = sym_raw[SYM_W] ? '0 : sym_raw[SYM_W-1:0];
  assign pair_val = PAIR_BITS'(held_q) * PAIR_BITS'(NUM_SYMBOLS) + PAIR_BITS'(sym);

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    chars_left_d = chars_left_q;
    held_d       = held_q;
    held_v_d     = held_v_q;
    bad_d        = bad_q;
    ovf_d        = ovf_q;
    pad_sel_d    = pad_sel_q;
    sh_load      = 1'b0;
    sh_value     = '0;
    sh_len       = '0;
    pk_ctrl.clear    = 1'b0;
    pk_ctrl.bad_char = bad_q;
    pk_ctrl.overflow = ovf_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.mode == MODE_BEGIN) begin
            // drop any open message and start over with the header
            active_d      = 1'b1;
            chars_left_d  = req_i.message_length;
            held_v_d      = 1'b0;
            bad_d         = 1'b0;
            ovf_d         = need > room_bits;
            pk_ctrl.clear = 1'b1;
            sh_load       = 1'b1;
            sh_value      = {MODE_IND, COUNT_BITS'(req_i.message_length)};
            sh_len        = LEN_W'(SH_W);
            state_d       = S_BODY;
          end else if (active_q && chars_left_q != '0) begin
            if (sym_raw[SYM_W]) begin
              bad_d = 1'b1;
            end
            chars_left_d = chars_left_q - MSG_LEN_W'(1);
            if (held_v_q) begin
              sh_load  = 1'b1;
              sh_value = {pair_val, {(SH_W-PAIR_BITS){1'b0}}};
              sh_len   = LEN_W'(PAIR_BITS);
              held_v_d = 1'b0;
            end else if (chars_left_q == MSG_LEN_W'(1)) begin
              // odd last character packs alone
              sh_load  = 1'b1;
              sh_value = {sym, {(SH_W-SYM_W){1'b0}}};
              sh_len   = LEN_W'(ODD_BITS);
            end else begin
              held_d   = sym;
              held_v_d = 1'b1;
            end
            state_d = S_BODY;
          end
        end
      end
      S_BODY: begin
        if (!sh_busy) begin
          state_d = (chars_left_q == '0) ? S_TERM : S_IDLE;
        end
      end
      S_TERM: begin
        // terminator zeros stop early once the last codeword closes
        if (pk_stat.sent < cap) begin
          sh_load = 1'b1;
          sh_len  = LEN_W'(TERM_BITS);
        end
        state_d = S_FILL;
      end
      S_FILL: begin
        if (!sh_busy) begin
          if (pk_stat.fill != '0) begin
            sh_load = 1'b1;
            sh_len  = LEN_W'(4'd8 - {1'b0, pk_stat.fill});
          end
          pad_sel_d = 1'b0;
          state_d   = S_PAD;
        end
      end
      S_PAD: begin
        if (!sh_busy) begin
          sh_load   = 1'b1;
          sh_value  = {(pad_sel_q ? PAD_B : PAD_A), {(SH_W-CW_W){1'b0}}};
          sh_len    = LEN_W'(CW_W);
          pad_sel_d = !pad_sel_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // the codeword that fills capacity ends the message
    if (pk_stat.close) begin
      state_d      = S_IDLE;
      active_d     = 1'b0;
      chars_left_d = '0;
      held_v_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      active_q     <= 1'b0;
      chars_left_q <= '0;
      held_v_q     <= 1'b0;
      bad_q        <= 1'b0;
      ovf_q        <= 1'b0;
      pad_sel_q    <= 1'b0;
      dc_q         <= DC_RESET;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      chars_left_q <= chars_left_d;
      held_v_q     <= held_v_d;
      bad_q        <= bad_d;
      ovf_q        <= ovf_d;
      pad_sel_q    <= pad_sel_d;
      if (data_codewords_we_i) begin
        dc_q <= data_codewords_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  qrad_bit_shifter #(
    .W     (SH_W),
    .LEN_W (LEN_W)
  ) u_shifter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (sh_load),
    .flush_i     (pk_stat.close),
    .value_i     (sh_value),
    .len_i       (sh_len),
    .bit_valid_o (sh_bit_valid),
    .bit_o       (sh_bit),
    .bit_ready_i (pk_bit_ready),
    .busy_o      (sh_busy)
  );

  qrad_byte_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bit_valid_i (sh_bit_valid),
    .bit_i       (sh_bit),
    .bit_ready_o (pk_bit_ready),
    .cap_i       (cap),
    .ctrl_i      (pk_ctrl),
    .stat_o      (pk_stat),
    .cw_o        (cw_o)
  );

  // Closing the message returns the sequencer to idle with no message open.
  a_close_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pk_stat.close |=> (state_q == S_IDLE) && !active_q)
    else $error("sequencer not idle after message close");

  // The shifter is loaded only once its previous field is fully sent.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sh_load |-> !sh_busy)
    else $error("shifter loaded while busy");

  // No partial codeword lingers without an open message.
  a_fill_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (pk_stat.fill == 3'd0) && !sh_busy)
    else $error("stream bits pending with no open message");

endmodule

// ===== rtl/qrad_bit_shifter.sv =====
// ----------------------------------------------------------------------------
// qrad_bit_shifter: MSB-first bit serializer
// Loads a left-aligned field and bit count; hands out one bit a cycle if ready.
// ----------------------------------------------------------------------------
module qrad_bit_shifter #(
  parameter int W     = 13,
  parameter int LEN_W = $clog2(W + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             flush_i,
  input  logic [W-1:0]     value_i,
  input  logic [LEN_W-1:0] len_i,
  output logic             bit_valid_o,
  output logic             bit_o,
  input  logic             bit_ready_i,
  output logic             busy_o
);

  logic [W-1:0]     sr_q, sr_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;

  assign bit_valid_o = (cnt_q != '0);
  assign bit_o       = sr_q[W-1];
  assign busy_o      = bit_valid_o;

  always_comb begin
    sr_d  = sr_q;
    cnt_d = cnt_q;
    if (flush_i) begin
      cnt_d = '0;
    end else if (load_i) begin
      sr_d  = value_i;
      cnt_d = len_i;
    end else if (bit_valid_o && bit_ready_i) begin
      // advance one bit
      sr_d  = {sr_q[W-2:0], 1'b0};
      cnt_d = cnt_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

endmodule

// ===== rtl/qrad_byte_packer.sv =====
// ----------------------------------------------------------------------------
// qrad_byte_packer: bit to codeword assembler with output register
// Gathers eight bits, numbers the codeword and closes the message at capacity.
// ----------------------------------------------------------------------------
module qrad_byte_packer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       bit_valid_i,
  input  logic                       bit_i,
  output logic                       bit_ready_o,
  input  logic [qrad_pkg::DC_W-1:0]  cap_i,
  input  qrad_pkg::pk_ctrl_t         ctrl_i,
  output qrad_pkg::pk_stat_t         stat_o,
  qrad_out_if.source                 cw_o
);
  import qrad_pkg::*;

  logic [6:0]      acc_q;
  logic [2:0]      fill_q;
  logic [DC_W-1:0] sent_q;
  logic            ov_q;
  logic [CW_W-1:0] cw_q;
  logic [IDX_W-1:0] idx_q;
  logic            last_q, bad_q, ovf_q;

  logic            take, full_byte, done;
  logic [DC_W:0]   sent_inc;

  assign bit_ready_o = (fill_q != 3'd7) || !ov_q || cw_o.ready;
  assign take        = bit_valid_i && bit_ready_o;
  assign full_byte   = take && (fill_q == 3'd7);
  assign sent_inc    = {1'b0, sent_q} + (DC_W+1)'(1);
  assign done        = sent_inc >= {1'b0, cap_i};

  assign stat_o.fill  = fill_q;
  assign stat_o.sent  = sent_q;
  assign stat_o.close = full_byte && done;

  assign cw_o.valid          = ov_q;
  assign cw_o.codeword       = cw_q;
  assign cw_o.codeword_index = idx_q;
  assign cw_o.last           = last_q;
  assign cw_o.bad_char       = bad_q;
  assign cw_o.overflow       = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sent_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        fill_q <= '0;
        sent_q <= '0;
      end else if (take) begin
        fill_q <= fill_q + 3'd1;
        if (full_byte) begin
          sent_q <= sent_inc[DC_W-1:0];
        end
      end
      if (full_byte) begin
        ov_q <= 1'b1;
      end else if (cw_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q <= {acc_q[5:0], bit_i};
    end
    if (full_byte) begin
      cw_q   <= {acc_q, bit_i};
      idx_q  <= sent_q[IDX_W-1:0];
      last_q <= done;
      bad_q  <= ctrl_i.bad_char;
      ovf_q  <= ctrl_i.overflow;
    end
  end

endmodule

// ===== tb/sv/qr_alphanumeric_data_encoder_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qr_alphanumeric_data_encoder_top_tb: self-checking bench of the encoder
// Feeds begin and character requests through a randomly idling driver and
// collects codewords with a randomly stalling monitor. A bit-level model of
// the alphanumeric encoding predicts every codeword, and the codewords are
// compared in order. The capacity register is swept between phases.
// ----------------------------------------------------------------------------
module qr_alphanumeric_data_encoder_top_tb;
  import qrad_pkg::*;

  localparam int          COUNT_BITS  = 9;
  localparam int          MAX_CW      = 64;
  localparam int          CLK_PERIOD  = 4;
  localparam int          IDLE_PCT    = 31;
  localparam int          DRAIN_WAIT  = 48;    // covers the longest silent request
  localparam int          HOLD_CYCLES = 300;
  localparam int          PHASE_ITEMS = 38;
  localparam int unsigned BUF_MASK    = 32'h3FFFF;

  typedef struct packed {
    logic                 mode;
    logic [MSG_LEN_W-1:0] len;
    logic [CHAR_W-1:0]    ch;
  } request_t;

  typedef struct packed {
    logic [CW_W-1:0]  codeword;
    logic [IDX_W-1:0] index;
    logic             last;
    logic             bad_char;
    logic             overflow;
  } codeword_t;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                dc_we;
  logic [DC_W-1:0]     dc_value;
  logic                rx_hold = 1'b0;
  int                  n_accepted = 0;
  int                  n_errors   = 0;
  request_t            pending[$];
  request_t            in_flight;
  codeword_t           cw_expected[$];
  codeword_t           seen;
  codeword_t           want;

  // Order of the 45 alphanumeric symbols; the position is the symbol value.
  string alnum_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";

  // Encoder model state.
  logic [DC_W-1:0] enc_dc     = DC_RESET;
  int unsigned     enc_bits   = 0;
  int unsigned     enc_fill   = 0;
  int unsigned     enc_held   = 0;
  bit              enc_held_v = 1'b0;
  int unsigned     enc_left   = 0;
  logic [DC_W-1:0] enc_sent   = '0;
  bit              enc_open   = 1'b0;
  bit              enc_bad    = 1'b0;
  bit              enc_ovf    = 1'b0;

  qrad_in_if  req_if ();
  qrad_out_if cw_if ();

  qr_alphanumeric_data_encoder_top #(
    .COUNT_BITS    (COUNT_BITS),
    .MAX_CODEWORDS (MAX_CW)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .data_codewords_we_i (dc_we),
    .data_codewords_i    (dc_value),
    .req_i               (req_if),
    .cw_o                (cw_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Encoder model
  // --------------------------------------------------------------------------

  // Saturate the register to the usable range of 1..MAX_CW codewords.
  function automatic int unsigned capacity_now();
    if (enc_dc == 0) return 1;
    if (enc_dc > MAX_CW) return MAX_CW;
    return enc_dc;
  endfunction

  // Map a character to its symbol; anything outside the table gives 64.
  function automatic int unsigned table_index(logic [CHAR_W-1:0] ch);
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      if (alnum_chars[i] == ch) return i;
    end
    return 64;
  endfunction

  // Append n bits to the stream, keeping an 18-bit window.
  function automatic void shift_in(int unsigned v, int unsigned n);
    enc_bits = ((enc_bits << n) | (v & ((32'd1 << n) - 1))) & BUF_MASK;
    enc_fill += n;
  endfunction

  // Record one codeword; the one that reaches capacity closes the message.
  function automatic void put_codeword(logic [CW_W-1:0] b);
    codeword_t   c;
    int unsigned cap;
    bit          done;
    cap        = capacity_now();
    c.codeword = b;
    c.index    = enc_sent[IDX_W-1:0];
    enc_sent   = enc_sent + 1'b1;
    done       = (enc_sent >= cap) || (enc_sent == 0);
    c.last     = done;
    c.bad_char = enc_bad;
    c.overflow = enc_ovf;
    cw_expected.push_back(c);
    if (done) begin
      enc_open   = 1'b0;
      enc_bits   = 0;
      enc_fill   = 0;
      enc_held_v = 1'b0;
      enc_held   = 0;
      enc_left   = 0;
    end
  endfunction

  // Cut every complete byte off the front of the stream.
  function automatic void flush_bytes();
    int unsigned b;
    while (enc_open && enc_fill >= 8) begin
      b        = (enc_bits >> (enc_fill - 8)) & 32'hFF;
      enc_fill -= 8;
      enc_bits &= (32'd1 << enc_fill) - 1;
      put_codeword(CW_W'(b));
    end
  endfunction

  // Terminator, zero fill to a byte boundary, then pads up to capacity.
  function automatic void close_message();
    int unsigned cap, used, room, k;
    if (!enc_open) return;
    cap  = capacity_now();
    used = enc_sent * 8 + enc_fill;
    room = (cap * 8 > used) ? cap * 8 - used : 0;
    shift_in(0, (room < TERM_BITS) ? room : TERM_BITS);
    flush_bytes();
    if (enc_open && enc_fill > 0) begin
      shift_in(0, 8 - enc_fill);
      flush_bytes();
    end
    k = 0;
    while (enc_open) begin
      put_codeword(k[0] ? PAD_B : PAD_A);
      k++;
    end
  endfunction

  // Advance the model by one accepted request.
  function automatic void encode_request(request_t r);
    int unsigned need, sym;
    if (r.mode == MODE_BEGIN) begin
      // A begin drops any open message and restarts the stream.
      need       = MODE_IND_BITS + COUNT_BITS + PAIR_BITS * (r.len >> 1)
                   + ODD_BITS * r.len[0];
      enc_bits   = 0;
      enc_fill   = 0;
      enc_held   = 0;
      enc_held_v = 1'b0;
      enc_sent   = '0;
      enc_open   = 1'b1;
      enc_left   = r.len;
      enc_bad    = 1'b0;
      enc_ovf    = need > capacity_now() * 8;
      shift_in(MODE_IND, MODE_IND_BITS);
      shift_in(r.len, COUNT_BITS);
      flush_bytes();
      if (enc_open && enc_left == 0) close_message();
      return;
    end
    // Characters with no open message are dropped silently.
    if (!enc_open || enc_left == 0) return;
    sym = table_index(r.ch);
    if (sym >= NUM_SYMBOLS) begin
      enc_bad = 1'b1;
      sym     = 0;
    end
    if (enc_held_v) begin
      shift_in(NUM_SYMBOLS * enc_held + sym, PAIR_BITS);
      enc_held_v = 1'b0;
      enc_held   = 0;
    end else begin
      enc_held   = sym;
      enc_held_v = 1'b1;
    end
    enc_left--;
    if (enc_left == 0 && enc_held_v) begin
      shift_in(enc_held, ODD_BITS);
      enc_held_v = 1'b0;
      enc_held   = 0;
    end
    flush_bytes();
    if (enc_open && enc_left == 0) close_message();
  endfunction

  // --------------------------------------------------------------------------
  // Request construction; unused payload fields carry random values
  // --------------------------------------------------------------------------

  function automatic request_t make_begin(int unsigned len);
    request_t r;
    r.mode = MODE_BEGIN;
    r.len  = MSG_LEN_W'(len);
    r.ch   = CHAR_W'($urandom_range(255));
    return r;
  endfunction

  function automatic request_t make_char(logic [CHAR_W-1:0] c);
    request_t r;
    r.mode = MODE_CHAR;
    r.len  = MSG_LEN_W'($urandom_range(511));
    r.ch   = c;
    return r;
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) pending.push_back(make_char(s[i]));
  endtask

  // Mostly well-formed messages with random content; a few carry stray
  // characters ahead, overlong lengths, or are cut short by the next begin.
  task automatic add_random_message(inout int items);
    int unsigned cap, fit, len, nchars, roll;
    cap  = capacity_now();
    fit  = (cap * 8 > 13) ? (cap * 8 - 13) * 2 / 11 : 0;
    roll = $urandom_range(99);
    if (roll < 5) begin
      repeat ($urandom_range(3, 1)) pending.push_back(make_char(CHAR_W'($urandom_range(255))));
    end
    if (roll >= 90) begin
      len    = $urandom_range(511, fit + 1);
      nchars = (len > 24) ? 24 : len;
    end else begin
      len    = $urandom_range((fit < 28) ? fit + 2 : 30);
      nchars = (roll >= 80) ? $urandom_range(len) : len;
    end
    pending.push_back(make_begin(len));
    repeat (nchars) begin
      if ($urandom_range(99) < 8) begin
        pending.push_back(make_char(CHAR_W'($urandom_range(255))));
      end else begin
        pending.push_back(make_char(alnum_chars[$urandom_range(NUM_SYMBOLS - 1)]));
      end
    end
    items += 1 + nchars;
  endtask

  // --------------------------------------------------------------------------
  // Phase control
  // --------------------------------------------------------------------------

  // Drain everything queued and predicted, then let any silent shifting end.
  task automatic wait_idle();
    while (pending.size() != 0 || req_if.valid || cw_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [DC_W-1:0] v);
    @(posedge clk_i);
    dc_we    <= 1'b1;
    dc_value <= v;
    @(posedge clk_i);
    dc_we    <= 1'b0;
    enc_dc   = v;
  endtask

  // Both sides run without gaps while this window is open.
  function automatic bit calm_window();
    return n_accepted >= 220 && n_accepted < 290;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present the next pending request, hold it until taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid          <= 1'b0;
      req_if.mode           <= MODE_BEGIN;
      req_if.message_length <= '0;
      req_if.char_code      <= '0;
      n_accepted            <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        encode_request(in_flight);
        n_accepted <= n_accepted + 1;
      end
      // Advance only when the current request is gone or none is shown.
      if (!req_if.valid || req_if.ready) begin
        if (pending.size() != 0 && (calm_window() || $urandom_range(99) >= IDLE_PCT)) begin
          in_flight             = pending.pop_front();
          req_if.valid          <= 1'b1;
          req_if.mode           <= in_flight.mode;
          req_if.message_length <= in_flight.len;
          req_if.char_code      <= in_flight.ch;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each codeword with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_if.ready <= 1'b0;
    end else begin
      if (cw_if.valid && cw_if.ready) begin
        seen = '{cw_if.codeword, cw_if.codeword_index, cw_if.last,
                 cw_if.bad_char, cw_if.overflow};
        if (cw_expected.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("%0t: unexpected codeword cw=%0d idx=%0d last=%b bad=%b ovf=%b",
                     $realtime, seen.codeword, seen.index, seen.last, seen.bad_char,
                     seen.overflow);
          end
        end else begin
          want = cw_expected.pop_front();
          if (seen !== want) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("%0t: codeword exp cw=%0d idx=%0d last=%b bad=%b ovf=%b",
                       $realtime, want.codeword, want.index, want.last, want.bad_char,
                       want.overflow);
              $display("%0t:          got cw=%0d idx=%0d last=%b bad=%b ovf=%b",
                       $realtime, seen.codeword, seen.index, seen.last, seen.bad_char,
                       seen.overflow);
            end
          end
        end
      end
      cw_if.ready <= !rx_hold && (calm_window() || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Hold the codeword output off for a long stretch while requests keep
  // coming, so the block backs up and stalls its request input.
  initial begin
    wait (n_accepted >= 40);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Drop the run if it hangs.
  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int              items;
    logic [DC_W-1:0] cap_val;
    logic [DC_W-1:0] phase_caps[8];
    phase_caps = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd13, 7'd0, 7'd40, 7'd7};

    // Drive every input to a known value before reset releases.
    dc_we                 = 1'b0;
    dc_value              = '0;
    req_if.valid          = 1'b0;
    req_if.mode           = MODE_BEGIN;
    req_if.message_length = '0;
    req_if.char_code      = '0;
    cw_if.ready           = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset capacity of 13 codewords.
    pending.push_back(make_begin(0));      // zero length: header then pads only
    pending.push_back(make_begin(3));
    add_text("A1:");                       // one pair plus an odd last symbol
    pending.push_back(make_begin(3));      // characters outside the table
    pending.push_back(make_char(8'h00));
    pending.push_back(make_char(8'hFF));
    add_text("a");                         // lowercase is outside the table too
    add_text("5");                         // no open message: ignored
    pending.push_back(make_begin(4));      // cut short by the next begin
    add_text("Z%");
    pending.push_back(make_begin(1));
    add_text(" ");
    pending.push_back(make_begin(511));    // overlong, left open on purpose
    add_text("09/*");
    wait_idle();
    // Lower capacity under the open message; the next codeword closes it.
    write_capacity(7'd2);
    add_text("+-.$");
    wait_idle();

    // Random phases across the register range, extremes included; each
    // phase ends with the sender paused until every codeword has come.
    for (int p = 0; p < 8; p++) begin
      cap_val = (p == 5) ? DC_W'($urandom_range(MAX_CW, 1)) : phase_caps[p];
      write_capacity(cap_val);
      items = 0;
      while (items < PHASE_ITEMS) add_random_message(items);
      wait_idle();
    end

    if (n_errors == 0 && cw_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/qrad_pkg.sv
rtl/qrad_if.sv
rtl/qrad_bit_shifter.sv
rtl/qrad_byte_packer.sv
rtl/qr_alphanumeric_data_encoder_top.sv
tb/sv/qr_alphanumeric_data_encoder_top_tb.sv
